// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante implies cons in the same cycle
`define AST_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// expr never holds
`define AST_NEVER(label, expr, msg) \
  `AST_IMPL(label, 1'b1, !(expr), msg)

`endif

// ===== hw/rtl/tcfw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcfw_pkg
// Shared types, character codes and helpers of the console cell writer.
// ----------------------------------------------------------------------------
package tcfw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 128;
  localparam int QDEPTH      = 2;
  localparam int ROW_MAX     = 255;
  localparam int CELL_IDX_W  = 14;
  localparam int DIG_N       = 10;

  localparam logic [7:0]  CH_PCT   = 8'd37;
  localparam logic [7:0]  CH_HAT   = 8'd94;
  localparam logic [7:0]  CH_NL    = 8'd10;
  localparam logic [7:0]  CH_ZERO  = 8'h30;
  localparam logic [7:0]  CH_X     = 8'h78;
  localparam logic [7:0]  NUM_ATTR = 8'd2;
  localparam logic [31:0] RECIP10  = 32'hCCCC_CCCD;

  typedef enum logic [1:0] {
    K_PLAIN   = 2'd0,
    K_NEWLINE = 2'd1,
    K_DEC     = 2'd2,
    K_HEX     = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  char_code;
    logic [7:0]  attribute;
    logic [31:0] argument_value;
    logic [2:0]  hex_top;
  } entry_t;

  typedef struct packed {
    logic cur_over;
    logic row_zero;
  } back_stat_t;

  function automatic logic [7:0] hex_glyph(input logic [3:0] nib);
    logic [7:0] g;
    if (nib < 4'd10) begin
      g = CH_ZERO + {4'b0, nib};
    end else begin
      g = 8'h37 + {4'b0, nib};
    end
    return g;
  endfunction

endpackage

// ===== hw/rtl/text_console_format_writer_unit.sv =====
// ----------------------------------------------------------------------------
// text_console_format_writer_unit
// Format character to text cell writer: plain cells, newline, decimal and
// hex argument expansion.
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  in      | input     | in_valid/in_ready, char_code, attribute, argument_value
//  out     | output    | out_valid/out_ready, cell_index, glyph, cell_attribute,
//          |           | out_of_range, last
//
//  Back stage per word: newline moves cursor and row only, plain character gives
//  one cell, hex the 0x prefix then digits, decimal one reciprocal multiply per
//  digit, then one cell per cycle out of the result register while out is ready.
//  Front takes words into a QUEUE_DEPTH entry queue while the back is busy.
//  Synchronous active-low reset; cursor clears to 0, row counter to 1.
//  out stalls hold the result register and the cell emitting states in place.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module text_console_format_writer_unit import tcfw_pkg::*; #(
  parameter int COLUMNS     = DEF_COLUMNS,
  parameter int ROWS        = DEF_ROWS,
  parameter int QUEUE_DEPTH = QDEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_char_code,
  input  logic [7:0]            in_attribute,
  input  logic [31:0]           in_argument_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CELL_IDX_W-1:0] out_cell_index,
  output logic [7:0]            out_glyph,
  output logic [7:0]            out_cell_attribute,
  output logic                  out_out_of_range,
  output logic                  out_last
);

  entry_t     q_wdata, q_rdata;
  logic       q_push, q_pop, q_full, q_empty;
  back_stat_t stat;

  tcfw_front u_front (
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_char_code      (in_char_code),
    .in_attribute      (in_attribute),
    .in_argument_value (in_argument_value),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_wdata           (q_wdata)
  );

  tcfw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  tcfw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_rdata            (q_rdata),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_cell_index     (out_cell_index),
    .out_glyph          (out_glyph),
    .out_cell_attribute (out_cell_attribute),
    .out_out_of_range   (out_out_of_range),
    .out_last           (out_last),
    .stat               (stat)
  );

  `AST_NEVER(a_cursor_bound, stat.cur_over, "cursor beyond end of store")
  `AST_NEVER(a_row_nonzero, stat.row_zero, "row counter at zero")
  `AST_IMPL(a_full_stall, q_full, !in_ready, "input ready with queue full")

endmodule

// ===== hw/rtl/tcfw_front.sv =====
// ----------------------------------------------------------------------------
// tcfw_front
// Input stage: accepts a word, classifies it, finds the top hex digit.
// ----------------------------------------------------------------------------
module tcfw_front import tcfw_pkg::*; (
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_code,
  input  logic [7:0]  in_attribute,
  input  logic [31:0] in_argument_value,
  input  logic        q_full,
  output logic        q_push,
  output entry_t      q_wdata
);

  kind_t      kind;
  logic [2:0] top;

  always_comb begin
    case (in_char_code)
      CH_NL:   kind = K_NEWLINE;
      CH_PCT:  kind = K_DEC;
      CH_HAT:  kind = K_HEX;
      default: kind = K_PLAIN;
    endcase
  end

  always_comb begin
    top = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (in_argument_value[i*4 +: 4] != 4'd0) begin
        top = 3'(i);
      end
    end
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_wdata.kind           = kind;
    q_wdata.char_code      = in_char_code;
    q_wdata.attribute      = in_attribute;
    q_wdata.argument_value = in_argument_value;
    q_wdata.hex_top        = top;
  end

endmodule

// ===== hw/rtl/tcfw_queue.sv =====
// ----------------------------------------------------------------------------
// tcfw_queue
// Small FIFO of classified words between front and back.
// ----------------------------------------------------------------------------
module tcfw_queue import tcfw_pkg::*; #(
  parameter int DEPTH = QDEPTH
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t wdata,
  input  logic   pop,
  output entry_t rdata,
  output logic   full,
  output logic   empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full    = cnt_r == CNT_W'(DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= wdata;
    end
  end

endmodule

// ===== hw/rtl/tcfw_back.sv =====
// ----------------------------------------------------------------------------
// tcfw_back
// Execution stage: cursor and row state, digit conversion, cell emission.
// ----------------------------------------------------------------------------
module tcfw_back import tcfw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  entry_t                q_rdata,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CELL_IDX_W-1:0] out_cell_index,
  output logic [7:0]            out_glyph,
  output logic [7:0]            out_cell_attribute,
  output logic                  out_out_of_range,
  output logic                  out_last,
  output back_stat_t            stat
);

  localparam int STORE = COLUMNS * ROWS;
  localparam int CUR_W = $clog2(STORE + 1);
  localparam int CX_W  = (CUR_W > CELL_IDX_W) ? CUR_W : CELL_IDX_W;
  localparam int TGT_W = $clog2(ROW_MAX * COLUMNS + 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_ONE    = 5'b00010,
    S_CONV   = 5'b00100,
    S_PREFIX = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CUR_W-1:0]  cursor_r, cursor_nxt;
  logic [7:0]        row_r, row_nxt;
  logic [7:0]        char_r, char_nxt, attr_r, attr_nxt;
  logic [31:0]       val_r, val_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic              pfx_r, pfx_nxt, is_hex_r, is_hex_nxt;
  logic [3:0]        dig_r [DIG_N];

  logic              out_valid_r, out_valid_nxt;
  logic [CELL_IDX_W-1:0] oidx_r;
  logic [7:0]        oglyph_r, oattr_r;
  logic              oor_r, olast_r;

  logic              can_load, emit, past, e_last;
  logic [7:0]        e_glyph, e_attr;
  logic [63:0]       prod;
  logic [31:0]       quot;
  logic [3:0]        q10_lo, dec_digit, nibble;
  logic [TGT_W-1:0]  target;
  logic [CX_W-1:0]   cur_ext;

  assign can_load  = !out_valid_r || out_ready;
  assign past      = cursor_r >= CUR_W'(STORE);
  assign cur_ext   = CX_W'(cursor_r);

  // v / 10 by reciprocal; remainder only needs the low nibble
  assign prod      = 64'(val_r) * 64'(RECIP10);
  assign quot      = 32'(prod[63:35]);
  assign q10_lo    = {quot[0], 3'b000} + {quot[2:0], 1'b0};
  assign dec_digit = val_r[3:0] - q10_lo;
  assign nibble    = 4'(val_r >> {cnt_r[2:0], 2'b00});
  assign target    = TGT_W'(row_r) * TGT_W'(COLUMNS);

  always_comb begin
    state_nxt  = state_r;
    cursor_nxt = cursor_r;
    row_nxt    = row_r;
    char_nxt   = char_r;
    attr_nxt   = attr_r;
    val_nxt    = val_r;
    cnt_nxt    = cnt_r;
    pfx_nxt    = pfx_r;
    is_hex_nxt = is_hex_r;
    q_pop      = 1'b0;
    emit       = 1'b0;
    e_glyph    = char_r;
    e_attr     = NUM_ATTR;
    e_last     = 1'b0;
    case (state_r)
      S_IDLE: begin
        q_pop = !q_empty;
        if (!q_empty) begin
          case (q_rdata.kind)
            K_NEWLINE: begin
              cursor_nxt = (target > TGT_W'(STORE)) ? CUR_W'(STORE) : CUR_W'(target);
              row_nxt    = (row_r == 8'(ROW_MAX)) ? row_r : row_r + 8'd1;
            end
            K_DEC: begin
              val_nxt    = q_rdata.argument_value;
              cnt_nxt    = 4'd0;
              is_hex_nxt = 1'b0;
              state_nxt  = S_CONV;
            end
            K_HEX: begin
              val_nxt    = q_rdata.argument_value;
              cnt_nxt    = {1'b0, q_rdata.hex_top};
              pfx_nxt    = 1'b0;
              is_hex_nxt = 1'b1;
              state_nxt  = S_PREFIX;
            end
            default: begin
              char_nxt  = q_rdata.char_code;
              attr_nxt  = q_rdata.attribute;
              state_nxt = S_ONE;
            end
          endcase
        end
      end
      S_ONE: begin
        emit    = 1'b1;
        e_glyph = char_r;
        e_attr  = attr_r;
        e_last  = 1'b1;
        if (can_load) begin
          state_nxt = S_IDLE;
        end
      end
      S_CONV: begin
        if (quot == 32'd0) begin
          state_nxt = S_EMIT;
        end else begin
          val_nxt = quot;
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      S_PREFIX: begin
        emit    = 1'b1;
        e_glyph = pfx_r ? CH_X : CH_ZERO;
        if (can_load) begin
          if (pfx_r) begin
            state_nxt = S_EMIT;
          end else begin
            pfx_nxt = 1'b1;
          end
        end
      end
      S_EMIT: begin
        emit    = 1'b1;
        e_glyph = is_hex_r ? hex_glyph(nibble) : CH_ZERO + {4'b0, dig_r[cnt_r]};
        e_last  = cnt_r == 4'd0;
        if (can_load) begin
          if (cnt_r == 4'd0) begin
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt = cnt_r - 4'd1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (emit && can_load && !past) begin
      cursor_nxt = cursor_r + 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (can_load) begin
      out_valid_nxt = emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cursor_r    <= '0;
      row_r       <= 8'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r   <= char_nxt;
    attr_r   <= attr_nxt;
    val_r    <= val_nxt;
    cnt_r    <= cnt_nxt;
    pfx_r    <= pfx_nxt;
    is_hex_r <= is_hex_nxt;
    if (state_r == S_CONV) begin
      dig_r[cnt_r] <= dec_digit;
    end
    if (emit && can_load) begin
      oidx_r   <= cur_ext[CELL_IDX_W-1:0];
      oglyph_r <= e_glyph;
      oattr_r  <= e_attr;
      oor_r    <= past;
      olast_r  <= e_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_cell_index     = oidx_r;
  assign out_glyph          = oglyph_r;
  assign out_cell_attribute = oattr_r;
  assign out_out_of_range   = oor_r;
  assign out_last           = olast_r;

  assign stat.cur_over = cursor_r > CUR_W'(STORE);
  assign stat.row_zero = row_r == 8'd0;

endmodule

// ===== verif/text_console_format_writer_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_format_writer_unit_tb
// Self-checking bench for the console cell writer. Directed words cover plain
// characters, code zero, decimal and hex arguments at their extremes and a
// newline that jumps back. Random lines of text and runs of blank lines then
// push the cursor past the store and the row counter into saturation. Every
// cell is checked against a cursor and row model kept in the bench, with
// bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module text_console_format_writer_unit_tb;
  import tcfw_pkg::*;

  localparam int COLUMNS     = DEF_COLUMNS;
  localparam int ROWS        = DEF_ROWS;
  localparam int STORE_CELLS = COLUMNS * ROWS;
  localparam int RAND_WORDS  = 400;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_AT     = 150;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 60;
  localparam int MAX_PRINTS  = 50;

  typedef struct packed {
    logic [7:0]  ch;
    logic [7:0]  attr;
    logic [31:0] arg;
    logic        drain;
  } word_t;

  typedef struct packed {
    logic [CELL_IDX_W-1:0] idx;
    logic [7:0]            glyph;
    logic [7:0]            attr;
    logic                  oor;
    logic                  last;
  } cell_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PULSE} rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_char_code = '0;
  logic [7:0]            in_attribute = '0;
  logic [31:0]           in_argument_value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [CELL_IDX_W-1:0] out_cell_index;
  logic [7:0]            out_glyph;
  logic [7:0]            out_cell_attribute;
  logic                  out_out_of_range;
  logic                  out_last;

  word_t       pending[$];
  cell_t       cell_q[$];
  int unsigned cursor_pos = 0;
  int unsigned row_cnt = 1;
  int          errors = 0;
  int          words_in = 0;
  int          cells_seen = 0;
  int          oor_seen = 0;
  int          newlines = 0;
  int unsigned cyc = 0;
  int          hold_cnt = 0;
  bit          hold_done = 1'b0;
  int          burst_left = 0;
  int          gap_left = 0;
  rx_mode_t    rx_mode = RX_OPEN;
  int          rx_left = 0;

  text_console_format_writer_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_char_code      (in_char_code),
    .in_attribute      (in_attribute),
    .in_argument_value (in_argument_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_cell_index    (out_cell_index),
    .out_glyph         (out_glyph),
    .out_cell_attribute(out_cell_attribute),
    .out_out_of_range  (out_out_of_range),
    .out_last          (out_last)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    return (nib < 4'd10) ? CH_ZERO + 8'(nib) : 8'h41 + 8'(nib) - 8'd10;
  endfunction

  // Cell writes caused by one word; updates cursor and row counter.
  task automatic expand_word(input word_t w);
    logic [7:0]  glyphs [0:9];
    int          n;
    int          i;
    int unsigned v;
    logic [7:0]  a;
    cell_t       c;
    n = 0;
    v = w.arg;
    a = NUM_ATTR;
    if (w.ch == CH_NL) begin
      newlines++;
      cursor_pos = (row_cnt * COLUMNS > STORE_CELLS) ? STORE_CELLS : row_cnt * COLUMNS;
      if (row_cnt < ROW_MAX) row_cnt++;
      return;
    end
    // glyphs collected least significant first
    if (w.ch == CH_PCT) begin
      do begin
        glyphs[n] = CH_ZERO + 8'(v % 10);
        v = v / 10;
        n++;
      end while (v != 0);
    end else if (w.ch == CH_HAT) begin
      do begin
        glyphs[n] = hex_char(v[3:0]);
        v = v >> 4;
        n++;
      end while (v != 0);
      glyphs[n] = CH_X;
      glyphs[n + 1] = CH_ZERO;
      n += 2;
    end else begin
      glyphs[0] = w.ch;
      n = 1;
      a = w.attr;
    end
    for (i = n - 1; i >= 0; i--) begin
      c.idx = cursor_pos[CELL_IDX_W-1:0];
      c.glyph = glyphs[i];
      c.attr = a;
      c.oor = (cursor_pos >= STORE_CELLS);
      c.last = (i == 0);
      if (!c.oor) cursor_pos++;
      cell_q.push_back(c);
    end
  endtask

  function automatic logic [31:0] rand_arg();
    int unsigned nbits;
    nbits = $urandom_range(0, 32);
    if (nbits == 32) return $urandom;
    return $urandom & ((32'd1 << nbits) - 32'd1);
  endfunction

  task automatic queue_word(input logic [7:0] ch, input logic [7:0] attr,
                            input logic [31:0] arg, input logic drain);
    word_t w;
    w.ch = ch;
    w.attr = attr;
    w.arg = arg;
    w.drain = drain;
    pending.push_back(w);
  endtask

  task automatic queue_text(input logic drain);
    logic [7:0] ch;
    case ($urandom_range(0, 9))
      0, 1, 2: ch = CH_PCT;
      3, 4:    ch = CH_HAT;
      default: ch = 8'($urandom_range(0, 255));
    endcase
    queue_word(ch, 8'($urandom_range(0, 255)), rand_arg(), drain);
  endtask

  // driver
  always @(posedge clk) begin
    word_t w;
    bit    nxt_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      nxt_valid = in_valid;
      if (in_valid && in_ready) begin
        w.ch = in_char_code;
        w.attr = in_attribute;
        w.arg = in_argument_value;
        w.drain = 1'b0;
        expand_word(w);
        words_in <= words_in + 1;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending.size() > 0 && !(pending[0].drain && cell_q.size() > 0)) begin
          w = pending.pop_front();
          in_char_code <= w.ch;
          in_attribute <= w.attr;
          in_argument_value <= w.arg;
          nxt_valid = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 12);
            gap_left = $urandom_range(1, 10);
          end
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // long output hold-off, once
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt <= 0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (!hold_done && words_in >= HOLD_AT) begin
      hold_cnt <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    bit rdy;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= rx_mode_t'($urandom_range(0, 3));
        rx_left <= $urandom_range(20, 150);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   rdy = 1'b1;
        RX_COIN:   rdy = 1'($urandom_range(0, 1));
        RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
        default:   rdy = cyc[2];
      endcase
      out_ready <= rdy && (hold_cnt == 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    cell_t e;
    if (rst_n && out_valid && out_ready) begin
      if (cell_q.size() == 0) begin
        report_mismatch($sformatf("unexpected cell idx=%0d glyph=%02h attr=%02h oor=%0b last=%0b",
                                  out_cell_index, out_glyph, out_cell_attribute,
                                  out_out_of_range, out_last));
      end else begin
        e = cell_q.pop_front();
        cells_seen++;
        if (e.oor) oor_seen++;
        if (out_cell_index !== e.idx || out_glyph !== e.glyph ||
            out_cell_attribute !== e.attr || out_out_of_range !== e.oor ||
            out_last !== e.last) begin
          report_mismatch($sformatf(
            "cell got idx=%0d glyph=%02h attr=%02h oor=%0b last=%0b, exp %0d %02h %02h %0b %0b",
            out_cell_index, out_glyph, out_cell_attribute, out_out_of_range, out_last,
            e.idx, e.glyph, e.attr, e.oor, e.last));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d cells outstanding", cyc, cell_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int n_rand;
    int k;
    int start;

    // directed: 84 cells on the first line, so the newline jumps back
    queue_word(8'd0, 8'h00, 32'h0000_0000, 1'b0);
    queue_word(8'd255, 8'hFF, 32'hFFFF_FFFF, 1'b0);
    queue_word(8'h41, 8'h5A, 32'h1234_5678, 1'b0);
    queue_word(CH_PCT, 8'h00, 32'd0, 1'b0);
    queue_word(CH_PCT, 8'hFF, 32'hFFFF_FFFF, 1'b0);
    queue_word(CH_HAT, 8'h00, 32'd0, 1'b0);
    queue_word(CH_HAT, 8'hA5, 32'hFFFF_FFFF, 1'b0);
    queue_word(CH_PCT, 8'h3C, 32'd1000000000, 1'b0);
    queue_word(CH_HAT, 8'hC3, 32'h89AB_CDEF, 1'b0);
    queue_word(CH_PCT, 8'h01, 32'd9, 1'b0);
    queue_word(CH_PCT, 8'h80, 32'd10, 1'b0);
    queue_word(CH_HAT, 8'h7F, 32'h10, 1'b0);
    queue_word(CH_PCT, 8'h55, 32'hFFFF_FFFF, 1'b0);
    queue_word(CH_PCT, 8'hAA, 32'hFFFF_FFFF, 1'b0);
    queue_word(CH_HAT, 8'h0F, 32'hFFFF_FFFF, 1'b0);
    queue_word(CH_NL, 8'h00, 32'd0, 1'b0);
    queue_word(CH_NL, 8'hFF, 32'hFFFF_FFFF, 1'b0);
    queue_word(CH_NL, 8'h5A, 32'hDEAD_BEEF, 1'b0);
    queue_word(CH_X, 8'hF0, 32'h0F0F_0F0F, 1'b0);
    queue_word(CH_PCT, 8'hFF, 32'd4294967295, 1'b0);

    // random lines of text and runs of blank lines
    start = pending.size();
    n_rand = 0;
    while (n_rand < RAND_WORDS) begin
      if ($urandom_range(0, 3) == 0) begin
        k = $urandom_range(5, 15);
        repeat (k) queue_word(CH_NL, 8'($urandom_range(0, 255)), rand_arg(),
                              $urandom_range(0, 39) == 0);
      end else begin
        k = $urandom_range(1, 4);
        repeat (k) queue_text(pending.size() == start || $urandom_range(0, 39) == 0);
        queue_word(CH_NL, 8'($urandom_range(0, 255)), rand_arg(), 1'b0);
        k++;
      end
      n_rand += k;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending.size() > 0 || in_valid) @(posedge clk);
    while (cell_q.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d words, %0d cells checked, %0d of them past the store",
             words_in, cells_seen, oor_seen);
    $display("%0d newlines, row counter at %0d, %0d mismatches", newlines, row_cnt, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== text_console_format_writer_unit.f =====
+incdir+hw/rtl
hw/rtl/tcfw_pkg.sv
hw/rtl/tcfw_front.sv
hw/rtl/tcfw_queue.sv
hw/rtl/tcfw_back.sv
hw/rtl/text_console_format_writer_unit.sv
verif/text_console_format_writer_unit_tb.sv
